>>> design/rljd_pkg.sv
// Shared package for the resistor-ladder joystick decoder.
// Key codes, register indexes, reset values, queue sizing and the queued item type.
// No dependencies.
package rljd_pkg;

  // Fixed counts
  localparam int NUM_LEVELS = 6;
  localparam int NUM_KEYS   = 5;

  // Field widths
  localparam int KEY_W      = 3;
  localparam int TIME_W     = 32;
  localparam int MS_W       = 16;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 16;
  localparam int DIST_W     = 16;
  localparam int HW_W       = DIST_W - 1;

  // Key codes
  localparam logic [KEY_W-1:0] KEY_NONE  = 3'd0;
  localparam logic [KEY_W-1:0] KEY_UP    = 3'd1;
  localparam logic [KEY_W-1:0] KEY_DOWN  = 3'd2;
  localparam logic [KEY_W-1:0] KEY_LEFT  = 3'd3;
  localparam logic [KEY_W-1:0] KEY_RIGHT = 3'd4;
  localparam logic [KEY_W-1:0] KEY_OK    = 3'd5;

  // Register indexes
  localparam logic [CFG_IDX_W-1:0] REG_LEVEL_UP    = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_LEVEL_DOWN  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_LEVEL_LEFT  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_LEVEL_RIGHT = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_LEVEL_OK    = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_LEVEL_IDLE  = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_DEBOUNCE    = 3'd6;
  localparam logic [CFG_IDX_W-1:0] REG_LONG_PRESS  = 3'd7;

  // Distance used when a level has no different neighbor
  localparam logic [DIST_W-1:0] NO_NEIGHBOUR = 16'hFFFF;

  // Reset values (levels are cut to the converter width)
  localparam logic [CFG_DATA_W-1:0] LEVEL_RESET [NUM_LEVELS] =
    '{16'd200, 16'd900, 16'd1600, 16'd2300, 16'd3000, 16'd4095};
  localparam logic [MS_W-1:0] DEBOUNCE_RESET   = 16'd25;
  localparam logic [MS_W-1:0] LONG_PRESS_RESET = 16'd1000;

  // Cycles from a level change until the windows are valid
  localparam logic [1:0] SETTLE_CYCLES = 2'd2;

  // Queue between matcher and press tracker
  localparam int QDEPTH = 2;
  localparam int PTR_W  = $clog2(QDEPTH);
  localparam int CNT_W  = $clog2(QDEPTH + 1);

  typedef struct packed {
    logic [KEY_W-1:0]  key;
    logic [TIME_W-1:0] now_ms;
  } item_t;

endpackage

>>> design/rljd_if.sv
// Handshake channels of the joystick decoder: sample input and press result.
// Depends on rljd_pkg.
interface rljd_in_if #(parameter int ADC_BITS = 12);
  import rljd_pkg::*;
  logic                valid;
  logic                ready;
  logic [ADC_BITS-1:0] adc_sample;
  logic [TIME_W-1:0]   now_ms;

  modport source (output valid, adc_sample, now_ms, input ready);
  modport sink   (input valid, adc_sample, now_ms, output ready);
endinterface

interface rljd_out_if;
  import rljd_pkg::*;
  logic             valid;
  logic             ready;
  logic [KEY_W-1:0] key_code;
  logic             long_press;

  modport source (output valid, key_code, long_press, input ready);
  modport sink   (input valid, key_code, long_press, output ready);
endinterface

>>> design/rljd_cfg.sv
// Configuration registers and the two-stage window half-width pipeline.
// Depends on rljd_pkg.
module rljd_cfg #(
  parameter int ADC_BITS = 12
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             cfg_we,
  input  logic [rljd_pkg::CFG_IDX_W-1:0]   cfg_idx,
  input  logic [rljd_pkg::CFG_DATA_W-1:0]  cfg_wdata,
  output logic [ADC_BITS-1:0]              level      [rljd_pkg::NUM_LEVELS],
  output logic [rljd_pkg::HW_W-1:0]        half_width [rljd_pkg::NUM_LEVELS],
  output logic [rljd_pkg::MS_W-1:0]        debounce_ms,
  output logic [rljd_pkg::MS_W-1:0]        long_press_ms,
  output logic                             settled
);
  import rljd_pkg::*;

  logic [ADC_BITS-1:0] level_r    [NUM_LEVELS];
  logic [MS_W-1:0]     debounce_r;
  logic [MS_W-1:0]     long_press_r;
  logic [1:0]          settle_r;
  logic [DIST_W-1:0]   dist_r     [NUM_LEVELS][NUM_LEVELS];
  logic [DIST_W-1:0]   dist_nxt   [NUM_LEVELS][NUM_LEVELS];
  logic [DIST_W-1:0]   best       [NUM_LEVELS];
  logic [HW_W-1:0]     half_r     [NUM_LEVELS];

  // Register file writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < NUM_LEVELS; i++) begin
        level_r[i] <= LEVEL_RESET[i][ADC_BITS-1:0];
      end
      debounce_r   <= DEBOUNCE_RESET;
      long_press_r <= LONG_PRESS_RESET;
    end else if (cfg_we) begin
      case (cfg_idx) inside
        [REG_LEVEL_UP:REG_LEVEL_IDLE]: level_r[cfg_idx] <= cfg_wdata[ADC_BITS-1:0];
        REG_DEBOUNCE:                  debounce_r       <= cfg_wdata[MS_W-1:0];
        REG_LONG_PRESS:                long_press_r     <= cfg_wdata[MS_W-1:0];
        default: ;
      endcase
    end
  end

  // Hold the input closed until the windows reflect the current levels
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      settle_r <= SETTLE_CYCLES;
    end else if (cfg_we) begin
      settle_r <= SETTLE_CYCLES;
    end else if (settle_r != 2'd0) begin
      settle_r <= settle_r - 2'd1;
    end
  end

  // Stage 1: pairwise distances, upper triangle only; equal levels count as none
  always_comb begin
    for (int i = 0; i < NUM_LEVELS; i++) begin
      for (int j = 0; j < NUM_LEVELS; j++) begin
        dist_nxt[i][j] = NO_NEIGHBOUR;
        if (i < j && level_r[i] != level_r[j]) begin
          dist_nxt[i][j] = (level_r[i] > level_r[j]) ?
                           DIST_W'(level_r[i] - level_r[j]) :
                           DIST_W'(level_r[j] - level_r[i]);
        end
      end
    end
  end

  // Stage 2: nearest neighbor per level, then halve
  always_comb begin
    for (int i = 0; i < NUM_LEVELS; i++) begin
      best[i] = NO_NEIGHBOUR;
      for (int j = 0; j < NUM_LEVELS; j++) begin
        if (i < j && dist_r[i][j] < best[i]) begin
          best[i] = dist_r[i][j];
        end else if (j < i && dist_r[j][i] < best[i]) begin
          best[i] = dist_r[j][i];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    dist_r <= dist_nxt;
    for (int i = 0; i < NUM_LEVELS; i++) begin
      half_r[i] <= best[i][DIST_W-1:1];
    end
  end

  assign level         = level_r;
  assign half_width    = half_r;
  assign debounce_ms   = debounce_r;
  assign long_press_ms = long_press_r;
  assign settled       = (settle_r == 2'd0);

endmodule

>>> design/rljd_front.sv
// Front end: accepts samples, matches them against the key windows, pushes items.
// Depends on rljd_pkg and rljd_in_if.
module rljd_front #(
  parameter int ADC_BITS = 12
) (
  rljd_in_if.sink                    in_bus,
  input  logic [ADC_BITS-1:0]        level      [rljd_pkg::NUM_LEVELS],
  input  logic [rljd_pkg::HW_W-1:0]  half_width [rljd_pkg::NUM_LEVELS],
  input  logic                       settled,
  input  logic                       q_full,
  output logic                       q_push,
  output rljd_pkg::item_t            q_item
);
  import rljd_pkg::*;

  localparam int SUM_W = ((ADC_BITS > HW_W) ? ADC_BITS : HW_W) + 1;

  logic [NUM_KEYS-1:0] hit;
  logic [KEY_W-1:0]    key;
  logic [SUM_W-1:0]    smp_ext;
  logic [SUM_W-1:0]    lv_ext  [NUM_KEYS];
  logic [SUM_W-1:0]    hw_ext  [NUM_KEYS];

  // Strictly inside: level - half < sample < level + half
  always_comb begin
    smp_ext = SUM_W'(in_bus.adc_sample);
    for (int i = 0; i < NUM_KEYS; i++) begin
      lv_ext[i] = SUM_W'(level[i]);
      hw_ext[i] = SUM_W'(half_width[i]);
      hit[i]    = (smp_ext < lv_ext[i] + hw_ext[i]) &&
                  (smp_ext + hw_ext[i] > lv_ext[i]);
    end
  end

  // First match wins, in key order
  always_comb begin
    key = KEY_NONE;
    for (int i = NUM_KEYS - 1; i >= 0; i--) begin
      if (hit[i]) begin
        key = KEY_UP + KEY_W'(i);
      end
    end
  end

  assign in_bus.ready  = settled && !q_full;
  assign q_push        = in_bus.valid && in_bus.ready;
  assign q_item.key    = key;
  assign q_item.now_ms = in_bus.now_ms;

endmodule

>>> design/rljd_queue.sv
// Two-entry queue of matched items between the front end and the press tracker.
// Depends on rljd_pkg.
module rljd_queue (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            push,
  input  rljd_pkg::item_t push_item,
  input  logic            pop,
  output logic            full,
  output logic            not_empty,
  output rljd_pkg::item_t head
);
  import rljd_pkg::*;

  item_t             slot_r [QDEPTH];
  logic [PTR_W-1:0]  wr_ptr_r;
  logic [PTR_W-1:0]  rd_ptr_r;
  logic [CNT_W-1:0]  cnt_r;

  // Store on push
  always_ff @(posedge clk) begin
    if (push) begin
      slot_r[wr_ptr_r] <= push_item;
    end
  end

  // Advance pointers and count
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= (wr_ptr_r == PTR_W'(QDEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
      end
      if (pop) begin
        rd_ptr_r <= (rd_ptr_r == PTR_W'(QDEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
      end
      if (push && !pop) begin
        cnt_r <= cnt_r + 1'b1;
      end else if (pop && !push) begin
        cnt_r <= cnt_r - 1'b1;
      end
    end
  end

  assign full      = (cnt_r == CNT_W'(QDEPTH));
  assign not_empty = (cnt_r != '0);
  assign head      = slot_r[rd_ptr_r];

endmodule

>>> design/rljd_back.sv
// Back end: press tracker (held key, start time, long flag) and the output register.
// Depends on rljd_pkg and rljd_out_if.
module rljd_back (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      q_not_empty,
  input  rljd_pkg::item_t           q_head,
  output logic                      q_pop,
  input  logic [rljd_pkg::MS_W-1:0] debounce_ms,
  input  logic [rljd_pkg::MS_W-1:0] long_press_ms,
  rljd_out_if.source                out_bus
);
  import rljd_pkg::*;

  logic [KEY_W-1:0]  held_key_r;
  logic [KEY_W-1:0]  held_key_nxt;
  logic [TIME_W-1:0] start_r;
  logic [TIME_W-1:0] start_nxt;
  logic              long_rep_r;
  logic              long_rep_nxt;
  logic              out_valid_r;
  logic [KEY_W-1:0]  out_key_r;
  logic [KEY_W-1:0]  out_key_nxt;
  logic              out_long_r;
  logic              out_long_nxt;
  logic [TIME_W-1:0] held_time;

  // Take the next item when the output register is free or being drained
  assign q_pop     = q_not_empty && (!out_valid_r || out_bus.ready);
  assign held_time = q_head.now_ms - start_r;

  // Press tracking
  always_comb begin
    held_key_nxt = q_head.key;
    start_nxt    = start_r;
    long_rep_nxt = long_rep_r;
    out_key_nxt  = KEY_NONE;
    out_long_nxt = 1'b0;
    if (held_key_r == KEY_NONE) begin
      if (q_head.key != KEY_NONE) begin
        start_nxt = q_head.now_ms;
      end
    end else if (q_head.key == KEY_NONE) begin
      // release: short press if held for at least the debounce time and not already reported as long
      if (!long_rep_r && held_time >= TIME_W'(debounce_ms)) begin
        out_key_nxt = held_key_r;
      end
      long_rep_nxt = 1'b0;
    end else if (q_head.key != held_key_r) begin
      // different key while held: cancel, keep the long flag
      held_key_nxt = KEY_NONE;
    end else if (!long_rep_r && held_time >= TIME_W'(long_press_ms)) begin
      out_key_nxt  = held_key_r;
      out_long_nxt = 1'b1;
      long_rep_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      held_key_r <= KEY_NONE;
      start_r    <= '0;
      long_rep_r <= 1'b0;
    end else if (q_pop) begin
      held_key_r <= held_key_nxt;
      start_r    <= start_nxt;
      long_rep_r <= long_rep_nxt;
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (q_pop) begin
      out_valid_r <= 1'b1;
    end else if (out_bus.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      out_key_r  <= out_key_nxt;
      out_long_r <= out_long_nxt;
    end
  end

  assign out_bus.valid      = out_valid_r;
  assign out_bus.key_code   = out_key_r;
  assign out_bus.long_press = out_long_r;

endmodule

>>> design/resistor_ladder_joystick_decoder.sv
// Top level of the resistor-ladder joystick decoder: configuration, matcher, queue, tracker.
// Depends on rljd_pkg, rljd_if, rljd_cfg, rljd_front, rljd_queue and rljd_back.
//
//   channel   direction  payload                      handshake
//   in_bus    in         adc_sample, now_ms           valid/ready
//   out_bus   out        key_code, long_press         valid/ready
//   cfg_*     in         cfg_idx, cfg_wdata           cfg_we, no wait
//
// One item per cycle sustained while the output is not stalled; a result passes from its sample
// through the match in the accepting cycle, a queue slot, then the tracker's output register.
// After reset and after every register write the input stays closed while the
// window pipeline settles.
// A stalled output fills the two-entry queue; the input then closes until a slot frees.
module resistor_ladder_joystick_decoder #(
  parameter int ADC_BITS = 12
) (
  input  logic                            clk,
  input  logic                            rst_n,
  rljd_in_if.sink                         in_bus,
  rljd_out_if.source                      out_bus,
  input  logic                            cfg_we,
  input  logic [rljd_pkg::CFG_IDX_W-1:0]  cfg_idx,
  input  logic [rljd_pkg::CFG_DATA_W-1:0] cfg_wdata
);
  import rljd_pkg::*;

  logic [ADC_BITS-1:0] level      [NUM_LEVELS];
  logic [HW_W-1:0]     half_width [NUM_LEVELS];
  logic [MS_W-1:0]     debounce_ms;
  logic [MS_W-1:0]     long_press_ms;
  logic                settled;
  logic                q_push;
  logic                q_pop;
  logic                q_full;
  logic                q_not_empty;
  item_t               q_item;
  item_t               q_head;

  rljd_cfg #(.ADC_BITS(ADC_BITS)) u_cfg (
    .clk           (clk),
    .rst_n         (rst_n),
    .cfg_we        (cfg_we),
    .cfg_idx       (cfg_idx),
    .cfg_wdata     (cfg_wdata),
    .level         (level),
    .half_width    (half_width),
    .debounce_ms   (debounce_ms),
    .long_press_ms (long_press_ms),
    .settled       (settled)
  );

  rljd_front #(.ADC_BITS(ADC_BITS)) u_front (
    .in_bus     (in_bus),
    .level      (level),
    .half_width (half_width),
    .settled    (settled),
    .q_full     (q_full),
    .q_push     (q_push),
    .q_item     (q_item)
  );

  rljd_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .push_item (q_item),
    .pop       (q_pop),
    .full      (q_full),
    .not_empty (q_not_empty),
    .head      (q_head)
  );

  rljd_back u_back (
    .clk           (clk),
    .rst_n         (rst_n),
    .q_not_empty   (q_not_empty),
    .q_head        (q_head),
    .q_pop         (q_pop),
    .debounce_ms   (debounce_ms),
    .long_press_ms (long_press_ms),
    .out_bus       (out_bus)
  );

endmodule

>>> design/rljd_checker.sv
// Port-level checks for the joystick decoder, attached to the top level by bind.
// Depends on rljd_pkg and resistor_ladder_joystick_decoder.
module rljd_checker (
  input logic                       clk,
  input logic                       rst_n,
  input logic                       in_valid,
  input logic                       in_ready,
  input logic                       out_valid,
  input logic                       out_ready,
  input logic [rljd_pkg::KEY_W-1:0] key_code,
  input logic                       long_press,
  input logic                       cfg_we
);
  import rljd_pkg::*;

  // Stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(key_code) && $stable(long_press))
    else $error("result changed while stalled");

  // The input is closed right after a register write, while the windows settle
  a_cfg_settle: assert property (@(posedge clk) disable iff (!rst_n)
    cfg_we |=> !in_ready)
    else $error("input open right after a register write");

  // Input closed right after reset
  a_reset_closed: assert property (@(posedge clk)
    !rst_n |=> !in_ready)
    else $error("input open right after reset");

  // A result starting from an empty output stems from an item taken by the input handshake
  a_no_invent: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> $past(in_valid && in_ready, 2))
    else $error("result without a preceding item");

endmodule

bind resistor_ladder_joystick_decoder rljd_checker u_rljd_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_valid   (in_bus.valid),
  .in_ready   (in_bus.ready),
  .out_valid  (out_bus.valid),
  .out_ready  (out_bus.ready),
  .key_code   (out_bus.key_code),
  .long_press (out_bus.long_press),
  .cfg_we     (cfg_we)
);
